[src/dvru_pkg.sv]
// Shared types, constants and op codes of the distance-vector route table.
// No dependencies; every other source file imports it.
`default_nettype none

package dvru_pkg;

    localparam int ROUTERS = 16;
    localparam int IDX_W   = $clog2(ROUTERS);
    localparam int COST_W  = 17;

    localparam logic [COST_W-1:0] INF_COST = COST_W'(100000);

    typedef enum logic [2:0] {
        OP_SET_LINK  = 3'd0,
        OP_LINK_DOWN = 3'd1,
        OP_DV_ENTRY  = 3'd2,
        OP_LOOKUP    = 3'd3,
        OP_ADVERT    = 3'd4
    } t_op;

    typedef struct packed {
        logic              valid;
        logic [COST_W-1:0] cost;
    } t_link;

    typedef struct packed {
        logic              known;
        logic [COST_W-1:0] cost;
        logic [IDX_W-1:0]  hop;
    } t_route;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  nbr;
        logic [IDX_W-1:0]  dest;
        logic [COST_W-1:0] val;
        logic              last;
    } t_item;

    typedef struct packed {
        logic              known;
        logic [COST_W-1:0] cost;
        logic [IDX_W-1:0]  hop;
        logic              changed;
        logic              advertise;
        logic              error;
    } t_result;

    typedef struct packed {
        logic   link_we;
        t_link  link_wdata;
        logic   route_we;
        t_route route_wdata;
        logic   pending_nxt;
    } t_update;

endpackage

`default_nettype wire

[src/dvru_link_mem.sv]
// Per-neighbor link memory: link cost array with registered read,
// plus a valid flop per neighbor cleared at reset. Depends on dvru_pkg.
`default_nettype none

module dvru_link_mem (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_rd_en,
    input  wire  [dvru_pkg::IDX_W-1:0] i_rd_addr,
    input  wire                       i_wr_en,
    input  wire  [dvru_pkg::IDX_W-1:0] i_wr_addr,
    input  dvru_pkg::t_link           i_wr_data,
    output dvru_pkg::t_link           o_rd_data
);
    import dvru_pkg::*;

    logic [COST_W-1:0] r_mem [ROUTERS];
    logic [ROUTERS-1:0] r_vld;
    logic [COST_W-1:0] r_rd_cost;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data.cost;
        end
        if (i_rd_en) begin
            r_rd_cost <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= i_wr_data.valid;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data.valid = r_rd_vld;
    assign o_rd_data.cost  = r_rd_vld ? r_rd_cost : '0;

endmodule

`default_nettype wire

[src/dvru_route_mem.sv]
// Per-destination route memory (known, cost, hop) with registered
// read; unwritten entries read as zero via reset-cleared valid flops. Uses dvru_pkg.
`default_nettype none

module dvru_route_mem (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_rd_en,
    input  wire  [dvru_pkg::IDX_W-1:0] i_rd_addr,
    input  wire                       i_wr_en,
    input  wire  [dvru_pkg::IDX_W-1:0] i_wr_addr,
    input  dvru_pkg::t_route          i_wr_data,
    output dvru_pkg::t_route          o_rd_data
);
    import dvru_pkg::*;

    t_route             r_mem [ROUTERS];
    logic [ROUTERS-1:0] r_vld;
    t_route             r_rd_data;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

[src/dvru_calc.sv]
// Route update datapath: saturating add, route selection, result fields and
// write-back values for one item. Purely combinational; uses dvru_pkg.
`default_nettype none

module dvru_calc (
    input  dvru_pkg::t_item            i_item,
    input  wire  [dvru_pkg::IDX_W-1:0] i_self,
    input  dvru_pkg::t_link            i_link,
    input  dvru_pkg::t_route           i_route,
    input  wire                        i_pending,
    output dvru_pkg::t_result          o_res,
    output dvru_pkg::t_update          o_upd
);
    import dvru_pkg::*;

    logic [COST_W:0]   sum_w;
    logic [COST_W-1:0] sum;
    logic              nbr_ok;
    logic              dest_self;
    logic              take;
    logic              ch;

    assign sum_w     = {1'b0, i_item.val} + {1'b0, i_link.cost};
    assign sum       = (sum_w > {1'b0, INF_COST}) ? INF_COST : sum_w[COST_W-1:0];
    assign nbr_ok    = (i_item.nbr != i_self) && i_link.valid;
    assign dest_self = (i_item.dest == i_self);
    // Take the advertised route when unknown, cheaper, tie won by lower
    // neighbor, or the current next hop reporting a longer path.
    assign take = !dest_self &&
                  (!i_route.known || (sum < i_route.cost) ||
                   ((sum == i_route.cost) && (i_item.nbr < i_route.hop)) ||
                   ((i_route.hop == i_item.nbr) && (sum > i_route.cost)));

    always_comb begin
        o_res = '0;
        o_upd = '0;
        o_upd.pending_nxt = i_pending;
        ch = 1'b0;
        case (i_item.op)
            OP_SET_LINK: begin
                if (i_item.nbr != i_self) begin
                    ch = !i_link.valid || (i_link.cost != i_item.val) ||
                         !i_route.known || (i_route.cost != i_item.val) ||
                         (i_route.hop != i_item.nbr);
                    o_upd.link_we     = 1'b1;
                    o_upd.link_wdata  = '{valid: 1'b1, cost: i_item.val};
                    o_upd.route_we    = 1'b1;
                    o_upd.route_wdata = '{known: 1'b1, cost: i_item.val, hop: i_item.nbr};
                    o_res.known     = 1'b1;
                    o_res.cost      = i_item.val;
                    o_res.hop       = i_item.nbr;
                    o_res.changed   = ch;
                    o_res.advertise = ch;
                end
            end
            OP_LINK_DOWN: begin
                if (!nbr_ok) begin
                    o_res.error = 1'b1;
                end else begin
                    ch = !i_route.known || (i_route.cost != INF_COST);
                    o_upd.route_we    = 1'b1;
                    o_upd.route_wdata = '{known: 1'b1, cost: INF_COST, hop: i_route.hop};
                    o_res.known     = 1'b1;
                    o_res.cost      = INF_COST;
                    o_res.hop       = i_route.hop;
                    o_res.changed   = ch;
                    o_res.advertise = ch;
                end
            end
            OP_DV_ENTRY: begin
                if (!nbr_ok) begin
                    o_res.error = 1'b1;
                end else begin
                    ch = take;
                    o_upd.route_we    = take;
                    o_upd.route_wdata = '{known: 1'b1, cost: sum, hop: i_item.nbr};
                    if (dest_self) begin
                        o_res.known = 1'b1;
                        o_res.hop   = i_self;
                    end else if (take) begin
                        o_res.known = 1'b1;
                        o_res.cost  = sum;
                        o_res.hop   = i_item.nbr;
                    end else begin
                        o_res.known = i_route.known;
                        o_res.cost  = i_route.cost;
                        o_res.hop   = i_route.hop;
                    end
                    o_res.changed = ch;
                    if (i_item.last) begin
                        o_res.advertise   = i_pending || ch;
                        o_upd.pending_nxt = 1'b0;
                    end else begin
                        o_upd.pending_nxt = i_pending || ch;
                    end
                end
            end
            OP_LOOKUP: begin
                if (dest_self) begin
                    o_res.known = 1'b1;
                    o_res.hop   = i_self;
                end else begin
                    o_res.known = i_route.known;
                    o_res.cost  = i_route.cost;
                    o_res.hop   = i_route.hop;
                end
            end
            OP_ADVERT: begin
                if (!nbr_ok) begin
                    o_res.error = 1'b1;
                end else if (dest_self) begin
                    o_res.known = 1'b1;
                    o_res.hop   = i_self;
                end else if (!i_route.known) begin
                    o_res.cost = INF_COST;
                end else begin
                    // Poison reverse toward the next hop.
                    o_res.known = 1'b1;
                    o_res.hop   = i_route.hop;
                    o_res.cost  = (i_route.hop == i_item.nbr) ? INF_COST : i_route.cost;
                end
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/distance_vector_route_update.sv]
// Distance-vector route table of one router: channels, sequencer, output register
// and assertions. Depends on dvru_pkg, dvru_link_mem, dvru_route_mem and dvru_calc.
//
// Input channel (i_in_valid / o_in_stall): one op per beat (set_link, link_down,
//   dv_entry, lookup or advert) with neighbor, dest, value and last.
// Output channel (o_out_valid / i_out_stall): exactly one result beat per input
//   beat, in order: known, cost, route hop, changed, advertise, error.
// Config: pulse i_cfg_we with i_cfg_wdata to set this router's index; write it
//   only while no item is in flight.
// Timing: the accept edge launches the link and route memory reads; the edge that
//   leaves the compute state with the output free computes, writes back and loads
//   the output register. One item at a time, through the read-then-write pass;
//   the input stalls while the item sits in the compute state.
// Reset: synchronous, active low. Clear the neighbor and route valid flops (the
//   tables read as all zero), the self index, the pending-change flag and the
//   output valid.
// Backpressure: a stalled result holds; one more item is still accepted and read,
//   then waits in the compute state until the output frees.
`default_nettype none

module distance_vector_route_update (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration
    input  wire                          i_cfg_we,
    input  wire  [dvru_pkg::IDX_W-1:0]   i_cfg_wdata,
    // input channel
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [2:0]                   i_op,
    input  wire  [dvru_pkg::IDX_W-1:0]   i_neighbor,
    input  wire  [dvru_pkg::IDX_W-1:0]   i_dest,
    input  wire  [dvru_pkg::COST_W-1:0]  i_value,
    input  wire                          i_last,
    // output channel
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic                         o_known,
    output logic [dvru_pkg::COST_W-1:0]  o_cost,
    output logic [dvru_pkg::IDX_W-1:0]   o_route_hop,
    output logic                         o_changed,
    output logic                         o_advertise,
    output logic                         o_error
);
    import dvru_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state            r_state, n_state;
    t_item             r_item;
    logic [IDX_W-1:0]  r_self;
    logic              r_pending;
    logic              r_out_vld;
    t_result           r_res;

    logic              in_fire;
    logic              out_free;
    logic              exec_fire;
    logic [COST_W-1:0] val_clamped;
    logic              route_addr_nbr;
    logic [IDX_W-1:0]  route_rd_addr;
    t_link             link_rd;
    t_route            route_rd;
    t_result           calc_res;
    t_update           calc_upd;

    // Accept only when no item is being worked on.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_vld || !i_out_stall;
    assign exec_fire  = (r_state == S_EXEC) && out_free;

    // Saturate oversized costs to infinity on entry.
    assign val_clamped = (i_value > INF_COST) ? INF_COST : i_value;

    // Link ops look at the route to the neighbor itself, the rest at dest.
    assign route_addr_nbr = (t_op'(i_op) == OP_SET_LINK) || (t_op'(i_op) == OP_LINK_DOWN);
    assign route_rd_addr  = route_addr_nbr ? i_neighbor : i_dest;

    dvru_link_mem u_link_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rd_addr (i_neighbor),
        .i_wr_en   (exec_fire && calc_upd.link_we),
        .i_wr_addr (r_item.nbr),
        .i_wr_data (calc_upd.link_wdata),
        .o_rd_data (link_rd)
    );

    dvru_route_mem u_route_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rd_addr (route_rd_addr),
        .i_wr_en   (exec_fire && calc_upd.route_we),
        .i_wr_addr (calc_upd.route_wdata.hop == r_item.nbr && r_item.op != OP_LINK_DOWN
                    && r_item.op != OP_SET_LINK ? r_item.dest : r_item.nbr),
        .i_wr_data (calc_upd.route_wdata),
        .o_rd_data (route_rd)
    );

    dvru_calc u_calc (
        .i_item    (r_item),
        .i_self    (r_self),
        .i_link    (link_rd),
        .i_route   (route_rd),
        .i_pending (r_pending),
        .o_res     (calc_res),
        .o_upd     (calc_upd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_self    <= '0;
            r_pending <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_self <= i_cfg_wdata;
            end
            if (exec_fire) begin
                r_pending <= calc_upd.pending_nxt;
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload: latch the item at accept, the result when computed.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.op   <= t_op'(i_op);
            r_item.nbr  <= i_neighbor;
            r_item.dest <= i_dest;
            r_item.val  <= val_clamped;
            r_item.last <= i_last;
        end
        if (exec_fire) begin
            r_res <= calc_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_known     = r_res.known;
    assign o_cost      = r_res.cost;
    assign o_route_hop = r_res.hop;
    assign o_changed   = r_res.changed;
    assign o_advertise = r_res.advertise;
    assign o_error     = r_res.error;

    // An accepted beat always moves to the compute state.
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_EXEC))
        else $error("accepted beat did not enter compute state");

    // A stalled result is never overwritten by the next item.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> (r_out_vld && $stable(r_res)))
        else $error("stalled result lost or changed");

    // A rejected item never reports a change, an advertisement or a known route.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.error) |-> (!r_res.changed && !r_res.advertise && !r_res.known))
        else $error("errored result carries route data");

    // Any table change leaves the reported route known.
    a_change_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.changed) |-> r_res.known)
        else $error("changed result reports unknown route");

endmodule

`default_nettype wire

[verif/distance_vector_route_update_tb.sv]
// Self-checking testbench of the distance-vector route table: a directed table, then random
// traffic, mostly advertisements, checked beat by beat against a local model of the table.
// Depends on dvru_pkg and distance_vector_route_update.
`default_nettype none

module distance_vector_route_update_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dvru_pkg::*;

    // op codes outside the package enum; the block must ignore them
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;
    localparam logic [COST_W-1:0] COST_MAX = '1;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BEATS   = 200;
    localparam int DRAIN_CYCLES  = 10;

    typedef struct packed {
        logic [2:0]        op;
        logic [IDX_W-1:0]  nbr;
        logic [IDX_W-1:0]  dest;
        logic [COST_W-1:0] val;
        logic              last;
    } t_route_beat;

    typedef struct {
        t_route_beat beat;
        logic        has_known;
        t_result     known_res;
    } t_table_row;

    typedef enum logic [1:0] {
        STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
    } t_stall_mode;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]    i_cfg_wdata = '0;
    logic                i_in_valid  = 1'b0;
    logic [2:0]          i_op        = '0;
    logic [IDX_W-1:0]    i_neighbor  = '0;
    logic [IDX_W-1:0]    i_dest      = '0;
    logic [COST_W-1:0]   i_value     = '0;
    logic                i_last      = 1'b0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_known;
    logic [COST_W-1:0]   o_cost;
    logic [IDX_W-1:0]    o_route_hop;
    logic                o_changed;
    logic                o_advertise;
    logic                o_error;

    // travels with each beat: a typed-in result that replaces the model's one
    logic    beat_has_known = 1'b0;
    t_result beat_known_res = '0;

    // local copy of the table, advanced on every accepted beat
    logic [COST_W-1:0] link_cost_tbl   [ROUTERS];
    logic              link_up_tbl     [ROUTERS];
    logic              route_known_tbl [ROUTERS];
    logic [COST_W-1:0] route_cost_tbl  [ROUTERS];
    logic [IDX_W-1:0]  route_hop_tbl   [ROUTERS];
    logic              adv_pending;
    logic [IDX_W-1:0]  self_idx;

    t_result route_results_due [$];
    int      fail_count = 0;

    // sender burst state
    int burst_left = 0;

    // receiver stall pattern
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;

    distance_vector_route_update dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_neighbor  (i_neighbor),
        .i_dest      (i_dest),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_known     (o_known),
        .o_cost      (o_cost),
        .o_route_hop (o_route_hop),
        .o_changed   (o_changed),
        .o_advertise (o_advertise),
        .o_error     (o_error)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Route as the table reports it; the own index is always a zero-cost route to itself.
    function automatic t_result read_route(logic [IDX_W-1:0] d);
        t_result r;
        r = '0;
        if (d == self_idx) begin
            r.known = 1'b1;
            r.hop   = self_idx;
        end else begin
            r.known = route_known_tbl[d];
            r.cost  = route_cost_tbl[d];
            r.hop   = route_hop_tbl[d];
        end
        return r;
    endfunction

    // Apply one beat to the local table and return the result it must produce.
    function automatic t_result route_table_step(t_route_beat b);
        t_result           r;
        logic [COST_W-1:0] v;
        logic [COST_W:0]   sum_wide;
        logic [COST_W-1:0] sum;
        logic              nbr_ok;
        logic              take;
        logic              ch;
        r      = '0;
        ch     = 1'b0;
        v      = (b.val > INF_COST) ? INF_COST : b.val;
        nbr_ok = (b.nbr != self_idx) && link_up_tbl[b.nbr];
        case (b.op)
            OP_SET_LINK: begin
                // a link to ourselves is dropped silently
                if (b.nbr != self_idx) begin
                    ch = !link_up_tbl[b.nbr] || link_cost_tbl[b.nbr] != v ||
                         !route_known_tbl[b.nbr] || route_cost_tbl[b.nbr] != v ||
                         route_hop_tbl[b.nbr] != b.nbr;
                    link_up_tbl[b.nbr]     = 1'b1;
                    link_cost_tbl[b.nbr]   = v;
                    route_known_tbl[b.nbr] = 1'b1;
                    route_cost_tbl[b.nbr]  = v;
                    route_hop_tbl[b.nbr]   = b.nbr;
                    r           = read_route(b.nbr);
                    r.changed   = ch;
                    r.advertise = ch;
                end
            end
            OP_LINK_DOWN: begin
                if (!nbr_ok) begin
                    r.error = 1'b1;
                end else begin
                    // only the direct route goes infinite; hop and link stay
                    ch = !route_known_tbl[b.nbr] || route_cost_tbl[b.nbr] != INF_COST;
                    route_known_tbl[b.nbr] = 1'b1;
                    route_cost_tbl[b.nbr]  = INF_COST;
                    r           = read_route(b.nbr);
                    r.changed   = ch;
                    r.advertise = ch;
                end
            end
            OP_DV_ENTRY: begin
                if (!nbr_ok) begin
                    r.error = 1'b1;
                end else begin
                    if (b.dest != self_idx) begin
                        sum_wide = {1'b0, v} + {1'b0, link_cost_tbl[b.nbr]};
                        sum  = (sum_wide > {1'b0, INF_COST}) ? INF_COST
                                                             : sum_wide[COST_W-1:0];
                        // unknown, cheaper, tie through a lower neighbor, or current hop grew
                        take = !route_known_tbl[b.dest] || sum < route_cost_tbl[b.dest] ||
                               (sum == route_cost_tbl[b.dest] && b.nbr < route_hop_tbl[b.dest]) ||
                               (route_hop_tbl[b.dest] == b.nbr && sum > route_cost_tbl[b.dest]);
                        if (take) begin
                            route_known_tbl[b.dest] = 1'b1;
                            route_cost_tbl[b.dest]  = sum;
                            route_hop_tbl[b.dest]   = b.nbr;
                            ch = 1'b1;
                        end
                    end
                    if (ch)
                        adv_pending = 1'b1;
                    r         = read_route(b.dest);
                    r.changed = ch;
                    if (b.last) begin
                        r.advertise = adv_pending;
                        adv_pending = 1'b0;
                    end
                end
            end
            OP_LOOKUP: begin
                r = read_route(b.dest);
            end
            OP_ADVERT: begin
                if (!nbr_ok) begin
                    r.error = 1'b1;
                end else begin
                    r = read_route(b.dest);
                    // poison reverse: never tell a neighbor a route that runs through it
                    if (!r.known) begin
                        r.cost = INF_COST;
                        r.hop  = '0;
                    end else if (b.dest != self_idx && r.hop == b.nbr) begin
                        r.cost = INF_COST;
                    end
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // Input monitor: advance the local table on each accepted beat and on a
    // register write. Both are sampled before this edge's updates land.
    always @(posedge i_clk) begin
        t_result res;
        if (!i_rst_n) begin
            for (int k = 0; k < ROUTERS; k++) begin
                link_cost_tbl[k]   = '0;
                link_up_tbl[k]     = 1'b0;
                route_known_tbl[k] = 1'b0;
                route_cost_tbl[k]  = '0;
                route_hop_tbl[k]   = '0;
            end
            adv_pending = 1'b0;
            self_idx    = '0;
        end else begin
            if (i_cfg_we)
                self_idx = i_cfg_wdata;
            if (i_in_valid && !o_in_stall) begin
                res = route_table_step('{i_op, i_neighbor, i_dest, i_value, i_last});
                if (beat_has_known)
                    res = beat_known_res;
                route_results_due.insert(route_results_due.size(), res);
            end
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Output checker: compare each accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (route_results_due.size() == 0) begin
                $error("result beat with no expectation waiting");
                fail_count++;
            end else begin
                want = route_results_due.pop_front();
                check_field("known", 32'(want.known), 32'(o_known));
                check_field("cost", 32'(want.cost), 32'(o_cost));
                check_field("route_hop", 32'(want.hop), 32'(o_route_hop));
                check_field("changed", 32'(want.changed), 32'(o_changed));
                check_field("advertise", 32'(want.advertise), 32'(o_advertise));
                check_field("error", 32'(want.error), 32'(o_error));
            end
        end
    end

    // Receiver: switch between stall modes at random, so that there are quiet
    // stretches, sparse stalls, long holds and a regular beat.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: i_out_stall <= stall_left[3];
            default:        i_out_stall <= 1'b0;
        endcase
    end

    // Present one beat and hold it until accepted. Bursts of random length are
    // separated by random gaps; a zero gap joins two bursts.
    task automatic send_beat(t_route_beat b, logic has_known, t_result known_res);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_op           <= b.op;
        i_neighbor     <= b.nbr;
        i_dest         <= b.dest;
        i_value        <= b.val;
        i_last         <= b.last;
        beat_has_known <= has_known;
        beat_known_res <= known_res;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until every expected result is back, then idle for DRAIN_CYCLES.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (route_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random cost: mostly small so that ties and hop changes happen often.
    function automatic logic [COST_W-1:0] rand_cost();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return INF_COST;
            2:       return COST_W'($urandom_range(int'(INF_COST) + 1, int'(COST_MAX)));
            3:       return COST_W'($urandom_range(0, int'(COST_MAX)));
            4:       return COST_W'($urandom_range(90000, int'(INF_COST)));
            default: return COST_W'($urandom_range(0, 30));
        endcase
    endfunction

    // Neighbor that is up most of the time, any index now and then.
    function automatic logic [IDX_W-1:0] pick_neighbor();
        logic [IDX_W-1:0] c;
        c = IDX_W'($urandom_range(0, ROUTERS - 1));
        if ($urandom_range(0, 9) != 0)
            for (int t = 0; t < 8 && !(link_up_tbl[c] && c != self_idx); t++)
                c = IDX_W'($urandom_range(0, ROUTERS - 1));
        return c;
    endfunction

    task automatic add_row(ref t_table_row rows[$], input logic [2:0] op,
                           input int nbr, input int dest, input int val, input int last,
                           input int has_known, input t_result known_res);
        t_table_row row;
        row.beat      = '{op, IDX_W'(nbr), IDX_W'(dest), COST_W'(val), (last != 0)};
        row.has_known = (has_known != 0);
        row.known_res = known_res;
        rows.insert(rows.size(), row);
    endtask

    initial begin
        t_table_row       rows[$];
        t_route_beat      b;
        logic [IDX_W-1:0] nb;
        int               sent;
        int               phase_end;
        int               pick;
        int               len;
        logic             broken;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; own index is 0 from reset. Typed-in results where obvious.
        add_row(rows, OP_LOOKUP,    0,  5, 0,      0, 1, '0);
        add_row(rows, OP_LOOKUP,    3,  0, 0,      0, 1, '{1'b1, '0, 4'd0, 1'b0, 1'b0, 1'b0});
        add_row(rows, OP_ADVERT,    3,  4, 0,      0, 1, '{1'b0, '0, 4'd0, 1'b0, 1'b0, 1'b1});
        add_row(rows, OP_DV_ENTRY,  3,  4, 7,      1, 1, '{1'b0, '0, 4'd0, 1'b0, 1'b0, 1'b1});
        add_row(rows, OP_LINK_DOWN, 3,  0, 0,      0, 1, '{1'b0, '0, 4'd0, 1'b0, 1'b0, 1'b1});
        // link to ourselves: dropped, all fields zero
        add_row(rows, OP_SET_LINK,  0,  0, 9,      0, 1, '0);
        // reserved ops, first with every field at zero, then with every field at its top value
        add_row(rows, OP_RSVD_FIRST, 0, 0, 0,      0, 1, '0);
        add_row(rows, OP_RSVD_LAST, 15, 15, int'(COST_MAX), 1, 1, '0);
        add_row(rows, OP_SET_LINK, 15,  0, int'(INF_COST), 0, 1,
                '{1'b1, INF_COST, 4'd15, 1'b1, 1'b1, 1'b0});
        add_row(rows, OP_SET_LINK,  1,  0, 0,      0, 1, '{1'b1, '0, 4'd1, 1'b1, 1'b1, 1'b0});
        add_row(rows, OP_SET_LINK,  1,  0, 0,      0, 1, '{1'b1, '0, 4'd1, 1'b0, 1'b0, 1'b0});
        // oversized cost saturates at infinity
        add_row(rows, OP_SET_LINK,  2,  0, int'(COST_MAX), 0, 1,
                '{1'b1, INF_COST, 4'd2, 1'b1, 1'b1, 1'b0});
        add_row(rows, OP_SET_LINK,  2,  0, 5,      0, 0, '0);
        // unknown destination, then an equal-cost offer from a higher neighbor
        add_row(rows, OP_DV_ENTRY,  1,  7, 10,     0, 0, '0);
        add_row(rows, OP_DV_ENTRY,  2,  7, 5,      0, 0, '0);
        add_row(rows, OP_DV_ENTRY,  2,  8, int'(COST_MAX), 1, 0, '0);
        // advertisement that only touches ourselves: no change, no advertise
        add_row(rows, OP_DV_ENTRY,  1,  0, 3,      1, 0, '0);
        add_row(rows, OP_DV_ENTRY,  2,  7, 0,      0, 0, '0);
        // current next hop got worse: the route follows it
        add_row(rows, OP_DV_ENTRY,  2,  7, 20,     1, 0, '0);
        add_row(rows, OP_ADVERT,    2,  7, 0,      0, 0, '0);
        add_row(rows, OP_ADVERT,    1,  7, 0,      0, 0, '0);
        add_row(rows, OP_ADVERT,    1,  9, 0,      0, 1,
                '{1'b0, INF_COST, 4'd0, 1'b0, 1'b0, 1'b0});
        add_row(rows, OP_ADVERT,    1,  0, 0,      0, 0, '0);
        add_row(rows, OP_ADVERT,    0,  7, 0,      0, 1, '{1'b0, '0, 4'd0, 1'b0, 1'b0, 1'b1});
        add_row(rows, OP_DV_ENTRY,  0,  7, 1,      1, 1, '{1'b0, '0, 4'd0, 1'b0, 1'b0, 1'b1});
        add_row(rows, OP_LINK_DOWN, 2,  0, 0,      0, 0, '0);
        // infinite link plus infinite distance stays infinite
        add_row(rows, OP_DV_ENTRY, 15,  4, int'(INF_COST), 1, 0, '0);

        foreach (rows[r])
            send_beat(rows[r].beat, rows[r].has_known, rows[r].known_res);

        // Random phases, each under its own router index: both extremes first.
        sent = 0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= (phase == 0) ? IDX_W'(ROUTERS - 1) :
                           (phase == 1) ? '0 : IDX_W'($urandom_range(0, ROUTERS - 1));
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
            phase_end = sent + PHASE_BEATS;
            while (sent < phase_end) begin
                pick = $urandom_range(0, 99);
                b    = '{3'($urandom_range(0, 7)), IDX_W'($urandom_range(0, ROUTERS - 1)),
                         IDX_W'($urandom_range(0, ROUTERS - 1)),
                         COST_W'($urandom_range(0, int'(COST_MAX))),
                         1'($urandom_range(0, 1))};
                if (pick < 50) begin
                    // well-formed advertisement from one neighbor; now and then a
                    // broken one with random last flags
                    nb     = pick_neighbor();
                    len    = $urandom_range(1, 6);
                    broken = ($urandom_range(0, 11) == 0);
                    for (int j = 0; j < len; j++) begin
                        b.op   = OP_DV_ENTRY;
                        b.nbr  = nb;
                        b.dest = IDX_W'($urandom_range(0, ROUTERS - 1));
                        b.val  = rand_cost();
                        b.last = broken ? 1'($urandom_range(0, 1)) : (j == len - 1);
                        send_beat(b, 1'b0, '0);
                        sent++;
                    end
                end else begin
                    if (pick < 62) begin
                        b.op  = OP_SET_LINK;
                        b.val = rand_cost();
                    end else if (pick < 68) begin
                        b.op  = OP_LINK_DOWN;
                        b.nbr = pick_neighbor();
                    end else if (pick < 82) begin
                        b.op  = OP_LOOKUP;
                    end else if (pick < 94) begin
                        b.op  = OP_ADVERT;
                        b.nbr = pick_neighbor();
                    end
                    // else keep the fully random beat as noise
                    send_beat(b, 1'b0, '0);
                    sent++;
                end
            end
        end

        drain();
        if (fail_count == 0)
            $display("PASS distance_vector_route_update");
        else
            $display("FAIL distance_vector_route_update");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #4000000;
        $display("FAIL distance_vector_route_update");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
src/dvru_pkg.sv
src/dvru_link_mem.sv
src/dvru_route_mem.sv
src/dvru_calc.sv
src/distance_vector_route_update.sv
verif/distance_vector_route_update_tb.sv
